### rtl/sip_pkg.sv
// Shared types, widths and codes of the scrub interval planner.
package sip_pkg;

	localparam int POS_W    = 40;
	localparam int LEN_W    = 24;
	localparam int SPD_W    = 24;
	localparam int FRAC_W   = 16;
	localparam int SPOS_W   = 42;
	localparam int SPEED_W  = 33;
	localparam int PROD_W   = 48;
	localparam int NUM_W    = 64;
	localparam int DEN_W    = 42;
	localparam int CNT_W    = 6;
	localparam int MODE_W   = 2;
	localparam int OP_W     = 2;
	localparam int STAT_W   = 2;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;
	localparam int REG_IDX_W = 3;

	localparam logic [POS_W-1:0]   POS_MAX   = '1;
	localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
	localparam logic [SPEED_W-1:0] SPEED_CAP = {1'b1, 32'd0};

	localparam logic [POS_W-1:0] RST_UPPER   = '1;
	localparam logic [SPD_W-1:0] RST_CEIL    = 24'd65536;
	localparam logic [SPD_W-1:0] RST_SILENCE = 24'd655;

	typedef enum logic [OP_W-1:0] {
		OP_RESTART = 2'd0,
		OP_REFILL  = 2'd1,
		OP_STOP    = 2'd2
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_PLAY    = 2'd0,
		STAT_SILENCE = 2'd1,
		STAT_NONE    = 2'd2,
		STAT_DEFER   = 2'd3
	} status_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_POS = 3'd0,
		REG_LOWER     = 3'd1,
		REG_UPPER     = 3'd2,
		REG_FLOOR     = 3'd3,
		REG_CEIL      = 3'd4,
		REG_STUTTER   = 3'd5,
		REG_SILENCE   = 3'd6,
		REG_MODE      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0]  start_pos;
		logic [POS_W-1:0]  lower;
		logic [POS_W-1:0]  upper;
		logic [SPD_W-1:0]  floor_spd;
		logic [SPD_W-1:0]  ceil_spd;
		logic [LEN_W-1:0]  stutter;
		logic [SPD_W-1:0]  silence_spd;
		logic [MODE_W-1:0] mode;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PLAN0, S_S1, S_DIST, S_SPDDIV, S_LIMIT, S_MINSP, S_DURDIV0,
		S_DURDIV, S_SILENCE, S_ADJ, S_ADJ2, S_BOUND, S_MD1, S_MD2, S_MD3,
		S_MDDIV, S_SEEK, S_SEEK2, S_COMMIT, S_EMIT, S_OUT
	} state_t;

endpackage

### rtl/sip_if.sv
// Request and result channel interfaces of the scrub interval planner.
interface sip_in_if;
	logic                                valid;
	logic                                ready;
	logic [sip_pkg::OP_W-1:0]            opcode;
	logic [sip_pkg::LEN_W-1:0]           request_length;
	logic [sip_pkg::POS_W-1:0]           target_position;
	logic signed [sip_pkg::SPD_W-1:0]    target_speed;
	logic                                seek_mode;

	modport source (output valid, opcode, request_length, target_position, target_speed,
		seek_mode, input ready);
	modport sink (input valid, opcode, request_length, target_position, target_speed,
		seek_mode, output ready);
endinterface

interface sip_out_if;
	logic                         valid;
	logic                         ready;
	logic [sip_pkg::STAT_W-1:0]   status;
	logic [sip_pkg::POS_W-1:0]    from_position;
	logic [sip_pkg::POS_W-1:0]    to_position;
	logic [sip_pkg::LEN_W-1:0]    span_length;

	modport source (output valid, status, from_position, to_position, span_length,
		input ready);
	modport sink (input valid, status, from_position, to_position, span_length,
		output ready);
endinterface

### rtl/sip_cfg.sv
// APB register file holding the planner configuration.
module sip_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sip_pkg::ADDR_W-1:0]   paddr,
	input  logic [sip_pkg::DATA_W-1:0]   pwdata,
	output logic [sip_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output sip_pkg::cfg_t                cfg
);

	sip_pkg::cfg_t     cfg_q;
	sip_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = sip_pkg::reg_idx_t'(paddr[sip_pkg::ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// write a register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_pos   <= '0;
			cfg_q.lower       <= '0;
			cfg_q.upper       <= sip_pkg::RST_UPPER;
			cfg_q.floor_spd   <= '0;
			cfg_q.ceil_spd    <= sip_pkg::RST_CEIL;
			cfg_q.stutter     <= '0;
			cfg_q.silence_spd <= sip_pkg::RST_SILENCE;
			cfg_q.mode        <= '0;
		end else if (wr_en) begin
			case (idx)
				sip_pkg::REG_START_POS: cfg_q.start_pos   <= pwdata[sip_pkg::POS_W-1:0];
				sip_pkg::REG_LOWER:     cfg_q.lower       <= pwdata[sip_pkg::POS_W-1:0];
				sip_pkg::REG_UPPER:     cfg_q.upper       <= pwdata[sip_pkg::POS_W-1:0];
				sip_pkg::REG_FLOOR:     cfg_q.floor_spd   <= pwdata[sip_pkg::SPD_W-1:0];
				sip_pkg::REG_CEIL:      cfg_q.ceil_spd    <= pwdata[sip_pkg::SPD_W-1:0];
				sip_pkg::REG_STUTTER:   cfg_q.stutter     <= pwdata[sip_pkg::LEN_W-1:0];
				sip_pkg::REG_SILENCE:   cfg_q.silence_spd <= pwdata[sip_pkg::SPD_W-1:0];
				sip_pkg::REG_MODE:      cfg_q.mode        <= pwdata[sip_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// read back the addressed register
	always_comb begin
		case (idx)
			sip_pkg::REG_START_POS: prdata = sip_pkg::DATA_W'(cfg_q.start_pos);
			sip_pkg::REG_LOWER:     prdata = sip_pkg::DATA_W'(cfg_q.lower);
			sip_pkg::REG_UPPER:     prdata = sip_pkg::DATA_W'(cfg_q.upper);
			sip_pkg::REG_FLOOR:     prdata = sip_pkg::DATA_W'(cfg_q.floor_spd);
			sip_pkg::REG_CEIL:      prdata = sip_pkg::DATA_W'(cfg_q.ceil_spd);
			sip_pkg::REG_STUTTER:   prdata = sip_pkg::DATA_W'(cfg_q.stutter);
			sip_pkg::REG_SILENCE:   prdata = sip_pkg::DATA_W'(cfg_q.silence_spd);
			sip_pkg::REG_MODE:      prdata = sip_pkg::DATA_W'(cfg_q.mode);
			default:                prdata = '0;
		endcase
	end

endmodule

### rtl/sip_mul.sv
// Shared 24 by 24 unsigned multiplier with a registered product.
module sip_mul (
	input  logic                         clk,
	input  logic [sip_pkg::LEN_W-1:0]    a,
	input  logic [sip_pkg::SPD_W-1:0]    b,
	output logic [sip_pkg::PROD_W-1:0]   prod_q
);

	// register the product every cycle
	always_ff @(posedge clk) begin
		prod_q <= sip_pkg::PROD_W'(a) * sip_pkg::PROD_W'(b);
	end

endmodule

### rtl/sip_div.sv
// Restoring divider, one quotient bit per cycle.
module sip_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sip_pkg::NUM_W-1:0]    num,
	input  logic [sip_pkg::DEN_W-1:0]    den,
	output sip_pkg::div_stat_t           stat,
	output logic [sip_pkg::NUM_W-1:0]    quot
);

	logic                         busy_q;
	logic                         done_q;
	logic [sip_pkg::CNT_W-1:0]    cnt_q;
	logic [sip_pkg::NUM_W-1:0]    q_q;
	logic [sip_pkg::DEN_W-1:0]    rem_q;
	logic [sip_pkg::DEN_W-1:0]    den_q;
	logic [sip_pkg::DEN_W:0]      rem_sh;
	logic                         fits;

	assign rem_sh = {rem_q, q_q[sip_pkg::NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	// control: count the steps, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift the dividend in, subtract when the divisor fits
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q   <= {q_q[sip_pkg::NUM_W-2:0], fits};
			rem_q <= fits ? sip_pkg::DEN_W'(rem_sh - {1'b0, den_q})
			              : rem_sh[sip_pkg::DEN_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = q_q;

endmodule

### rtl/scrub_interval_planner.sv
// Scrub interval planner: sequencer around a shared multiplier and divider.
// Restart, stop and unknown codes are taken in the idle state and give no result.
// A first refill outside keyboard mode skips planning and goes straight to the emit state.
// A planned refill runs through the plan states, with up to three 64-step divisions on
// the shared restoring divider; one item is in flight at a time.
// Reset clears all session state and the registers to their listed reset values.
module scrub_interval_planner (
	input  logic                         clk,
	input  logic                         arst_n,
	sip_in_if.sink                       in_ch,
	sip_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sip_pkg::ADDR_W-1:0]   paddr,
	input  logic [sip_pkg::DATA_W-1:0]   pwdata,
	output logic [sip_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	localparam int PW = sip_pkg::POS_W;
	localparam int SW = sip_pkg::SPOS_W;
	localparam int LW = sip_pkg::LEN_W;
	localparam int VW = sip_pkg::SPEED_W;

	function automatic logic signed [SW-1:0] to_s(input logic [PW-1:0] p);
		to_s = $signed({{(SW-PW){1'b0}}, p});
	endfunction

	function automatic logic signed [SW-1:0] clamp_pos(input logic signed [SW-1:0] s,
			input logic [PW-1:0] lo, input logic [PW-1:0] hi);
		logic signed [SW-1:0] t;
		t = (s < to_s(hi)) ? s : to_s(hi);
		clamp_pos = (t > to_s(lo)) ? t : to_s(lo);
	endfunction

	function automatic logic [LW-1:0] sat_add(input logic [LW-1:0] a, input logic [LW-1:0] b);
		logic [LW:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[LW] ? sip_pkg::LEN_MAX : s[LW-1:0];
	endfunction

	sip_pkg::cfg_t          cfg;
	sip_pkg::state_t        state_q, state_d;
	sip_pkg::div_stat_t     div_stat;

	// session state
	logic [PW-1:0]          int_start_q, int_end_q, goal_q;
	logic                   goal_vld_q, started_q, stopped_q;
	logic [LW-1:0]          pend_play_q, pend_sil_q, defer_q;

	// working registers of one plan
	logic signed [SW-1:0]   s0_q, s1_q, ns1_q;
	logic [LW-1:0]          dur_q, dur_in_q;
	logic [VW-1:0]          speed_q;
	logic [sip_pkg::SPD_W-1:0] minsp_q;
	logic [PW-1:0]          ng_q;
	logic                   ngv_q, adj_q, silent_q, seek_q;
	logic [PW-1:0]          tgt_q, an_q;
	logic [sip_pkg::DEN_W-1:0] ad_q;
	logic signed [sip_pkg::SPD_W-1:0] tspd_q;
	logic [sip_pkg::PROD_W-1:0] lo_q;

	// result register
	logic                   out_vld_q;
	sip_pkg::status_t       out_stat_q;
	logic [PW-1:0]          out_from_q, out_to_q;
	logic [LW-1:0]          out_len_q;

	// shared units
	logic [LW-1:0]              mul_a;
	logic [sip_pkg::SPD_W-1:0]  mul_b;
	logic [sip_pkg::PROD_W-1:0] prod_q;
	logic                       div_start;
	logic [sip_pkg::NUM_W-1:0]  div_num, quot;
	logic [sip_pkg::DEN_W-1:0]  div_den;

	// combinational helpers
	logic                       in_acc, plain_first, by_speed;
	logic signed [SW-1:0]       s0_init, ns1_c, num_c, den_c, rnd_s, seek_s0;
	logic [SW-1:0]              dist_c, an_c, ad_c;
	logic [VW-1:0]              rnd_c, ceil_v, min_v;
	logic [sip_pkg::SPD_W-1:0]  mag_c, seek_spd, fl_min;
	logic [LW-1:0]              dur_new;
	logic                       goal_hit, s1_in_range, md_zero;

	sip_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	sip_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	sip_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.stat(div_stat), .quot(quot)
	);

	assign in_acc      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == sip_pkg::S_IDLE);
	assign plain_first = !started_q && !cfg.mode[1];
	assign by_speed    = cfg.mode[0];
	assign s0_init     = clamp_pos(to_s(cfg.start_pos), cfg.lower, cfg.upper);
	assign dur_new     = sat_add(in_ch.request_length, defer_q);

	assign mag_c  = tspd_q[sip_pkg::SPD_W-1] ? (~$unsigned(tspd_q) + 1'b1) : $unsigned(tspd_q);
	assign rnd_c  = VW'(({1'b0, prod_q} + (49'd1 << (sip_pkg::FRAC_W - 1))) >> sip_pkg::FRAC_W);
	assign rnd_s  = $signed({{(SW-VW){1'b0}}, rnd_c});
	assign dist_c = (s1_q > s0_q) ? $unsigned(s1_q - s0_q) : $unsigned(s0_q - s1_q);
	assign ceil_v = VW'(cfg.ceil_spd);
	assign fl_min = (cfg.floor_spd < cfg.ceil_spd) ? cfg.floor_spd : cfg.ceil_spd;
	assign min_v  = VW'(minsp_q);

	assign goal_hit    = goal_vld_q && (to_s(goal_q) == s1_q);
	assign s1_in_range = (s1_q >= 0) && (s1_q <= to_s(sip_pkg::POS_MAX));

	assign ns1_c   = clamp_pos(s1_q, cfg.lower, cfg.upper);
	assign num_c   = ns1_c - s0_q;
	assign den_c   = s1_q - s0_q;
	assign an_c    = (num_c < 0) ? $unsigned(-num_c) : $unsigned(num_c);
	assign ad_c    = (den_c < 0) ? $unsigned(-den_c) : $unsigned(den_c);
	assign md_zero = (num_c == 0) || ((num_c > 0) != (den_c > 0));

	assign seek_spd = (ceil_v < speed_q) ? cfg.ceil_spd : speed_q[sip_pkg::SPD_W-1:0];
	assign seek_s0  = (s0_q < s1_q) ? (s1_q - rnd_s) : (s1_q + rnd_s);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sip_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and operand selection for the shared units
	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			sip_pkg::S_IDLE: begin
				if (in_acc && in_ch.opcode == sip_pkg::OP_REFILL) begin
					state_d = plain_first ? sip_pkg::S_EMIT : sip_pkg::S_PLAN0;
				end
			end
			sip_pkg::S_PLAN0: begin
				mul_a   = dur_q;
				mul_b   = mag_c;
				state_d = by_speed ? sip_pkg::S_S1 : sip_pkg::S_DIST;
			end
			sip_pkg::S_S1: state_d = sip_pkg::S_DIST;
			sip_pkg::S_DIST: begin
				if (dur_q == '0) begin
					state_d = sip_pkg::S_LIMIT;
				end else begin
					div_start = 1'b1;
					div_num   = sip_pkg::NUM_W'({dist_c, {sip_pkg::FRAC_W{1'b0}}});
					div_den   = sip_pkg::DEN_W'(dur_q);
					state_d   = sip_pkg::S_SPDDIV;
				end
			end
			sip_pkg::S_SPDDIV: if (div_stat.done) state_d = sip_pkg::S_LIMIT;
			sip_pkg::S_LIMIT: state_d = sip_pkg::S_MINSP;
			sip_pkg::S_MINSP: begin
				if (speed_q < min_v && !((s0_q != s1_q) && seek_q)) begin
					mul_a   = speed_q[sip_pkg::SPD_W-1:0];
					mul_b   = dur_q;
					state_d = sip_pkg::S_DURDIV0;
				end else begin
					state_d = sip_pkg::S_SILENCE;
				end
			end
			sip_pkg::S_DURDIV0: begin
				div_start = 1'b1;
				div_num   = sip_pkg::NUM_W'({prod_q, 1'b0}) + sip_pkg::NUM_W'(minsp_q);
				div_den   = sip_pkg::DEN_W'({minsp_q, 1'b0});
				state_d   = sip_pkg::S_DURDIV;
			end
			sip_pkg::S_DURDIV: if (div_stat.done) state_d = sip_pkg::S_SILENCE;
			sip_pkg::S_SILENCE: state_d = sip_pkg::S_ADJ;
			sip_pkg::S_ADJ: begin
				if (adj_q && !seek_q) begin
					mul_a   = speed_q[sip_pkg::SPD_W-1:0];
					mul_b   = dur_q;
					state_d = sip_pkg::S_ADJ2;
				end else begin
					state_d = sip_pkg::S_BOUND;
				end
			end
			sip_pkg::S_ADJ2: state_d = sip_pkg::S_BOUND;
			sip_pkg::S_BOUND: begin
				if (s1_q == s0_q) begin
					state_d = sip_pkg::S_SEEK;
				end else if (seek_q && dur_q < cfg.stutter) begin
					state_d = sip_pkg::S_OUT;
				end else if (ns1_c != s1_q && !md_zero && an_c < ad_c) begin
					state_d = sip_pkg::S_MD1;
				end else begin
					state_d = sip_pkg::S_SEEK;
				end
			end
			sip_pkg::S_MD1: begin
				mul_a   = dur_q;
				mul_b   = an_q[sip_pkg::SPD_W-1:0];
				state_d = sip_pkg::S_MD2;
			end
			sip_pkg::S_MD2: begin
				mul_a   = dur_q;
				mul_b   = sip_pkg::SPD_W'(an_q[PW-1:sip_pkg::SPD_W]);
				state_d = sip_pkg::S_MD3;
			end
			sip_pkg::S_MD3: begin
				div_start = 1'b1;
				div_num   = sip_pkg::NUM_W'(lo_q)
				          + {prod_q[sip_pkg::NUM_W-sip_pkg::SPD_W-1:0], {sip_pkg::SPD_W{1'b0}}};
				div_den   = ad_q;
				state_d   = sip_pkg::S_MDDIV;
			end
			sip_pkg::S_MDDIV: if (div_stat.done) state_d = sip_pkg::S_SEEK;
			sip_pkg::S_SEEK: begin
				if (seek_q && !silent_q) begin
					mul_a   = seek_spd;
					mul_b   = dur_q;
					state_d = sip_pkg::S_SEEK2;
				end else begin
					state_d = sip_pkg::S_COMMIT;
				end
			end
			sip_pkg::S_SEEK2:  state_d = sip_pkg::S_COMMIT;
			sip_pkg::S_COMMIT: state_d = sip_pkg::S_EMIT;
			sip_pkg::S_EMIT:   state_d = sip_pkg::S_OUT;
			sip_pkg::S_OUT:    if (out_ch.ready) state_d = sip_pkg::S_IDLE;
			default:           state_d = sip_pkg::S_IDLE;
		endcase
	end

	// session state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_start_q <= '0;
			int_end_q   <= '0;
			goal_q      <= '0;
			goal_vld_q  <= 1'b0;
			pend_play_q <= '0;
			pend_sil_q  <= '0;
			defer_q     <= '0;
			started_q   <= 1'b0;
			stopped_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			case (state_q)
				sip_pkg::S_IDLE: begin
					if (in_acc) begin
						case (in_ch.opcode)
							sip_pkg::OP_RESTART: begin
								started_q <= 1'b0;
								stopped_q <= 1'b0;
								defer_q   <= '0;
							end
							sip_pkg::OP_STOP: begin
								stopped_q <= 1'b1;
								started_q <= 1'b0;
							end
							sip_pkg::OP_REFILL: begin
								if (plain_first) begin
									int_start_q <= s0_init[PW-1:0];
									int_end_q   <= s0_init[PW-1:0];
									goal_vld_q  <= 1'b0;
									goal_q      <= '0;
									pend_play_q <= in_ch.request_length;
									pend_sil_q  <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				sip_pkg::S_BOUND: begin
					// defer a stutter that is too short
					if (s1_q != s0_q && seek_q && dur_q < cfg.stutter) begin
						defer_q   <= sat_add(defer_q, dur_in_q);
						out_vld_q <= 1'b1;
					end
				end
				sip_pkg::S_COMMIT: begin
					int_start_q <= s0_q[PW-1:0];
					int_end_q   <= s1_q[PW-1:0];
					goal_q      <= ng_q;
					goal_vld_q  <= ngv_q;
					pend_play_q <= dur_q;
					pend_sil_q  <= (dur_q < dur_in_q) ? (dur_in_q - dur_q) : '0;
					defer_q     <= '0;
				end
				sip_pkg::S_EMIT: begin
					started_q <= 1'b1;
					out_vld_q <= 1'b1;
					if (!stopped_q) begin
						if (pend_play_q != '0) begin
							pend_play_q <= '0;
						end else begin
							pend_sil_q <= '0;
						end
					end
				end
				sip_pkg::S_OUT: begin
					if (out_ch.ready) out_vld_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			sip_pkg::S_BOUND: begin
				out_stat_q <= sip_pkg::STAT_DEFER;
				out_from_q <= '0;
				out_to_q   <= '0;
				out_len_q  <= '0;
			end
			sip_pkg::S_EMIT: begin
				if (stopped_q) begin
					out_stat_q <= sip_pkg::STAT_NONE;
					out_from_q <= '0;
					out_to_q   <= '0;
					out_len_q  <= '0;
				end else if (pend_play_q != '0) begin
					out_stat_q <= sip_pkg::STAT_PLAY;
					out_from_q <= int_start_q;
					out_to_q   <= int_end_q;
					out_len_q  <= pend_play_q;
				end else if (pend_sil_q != '0) begin
					out_stat_q <= sip_pkg::STAT_SILENCE;
					out_from_q <= int_end_q;
					out_to_q   <= int_end_q;
					out_len_q  <= pend_sil_q;
				end else begin
					out_stat_q <= sip_pkg::STAT_NONE;
					out_from_q <= '0;
					out_to_q   <= '0;
					out_len_q  <= '0;
				end
			end
			default: ;
		endcase
	end

	// plan datapath: one step per sequencer state
	always_ff @(posedge clk) begin
		case (state_q)
			sip_pkg::S_IDLE: begin
				dur_q    <= dur_new;
				dur_in_q <= dur_new;
				s0_q     <= started_q ? to_s(int_end_q) : s0_init;
				seek_q   <= in_ch.seek_mode;
				tgt_q    <= in_ch.target_position;
				tspd_q   <= in_ch.target_speed;
				adj_q    <= 1'b0;
				silent_q <= 1'b0;
			end
			sip_pkg::S_PLAN0: if (!by_speed) s1_q <= to_s(tgt_q);
			sip_pkg::S_S1: begin
				s1_q <= tspd_q[sip_pkg::SPD_W-1] ? (s0_q - rnd_s) : (s0_q + rnd_s);
			end
			sip_pkg::S_DIST: begin
				if (dur_q == '0) speed_q <= (dist_c != '0) ? sip_pkg::SPEED_CAP : '0;
			end
			sip_pkg::S_SPDDIV: begin
				if (div_stat.done) begin
					speed_q <= (quot[sip_pkg::NUM_W-1:32] != '0) ? sip_pkg::SPEED_CAP
					                                           : quot[VW-1:0];
				end
			end
			sip_pkg::S_LIMIT: begin
				// clamp to the ceiling, or keep catching up at it on a standing goal
				minsp_q <= fl_min;
				ngv_q   <= 1'b0;
				ng_q    <= '0;
				if (!seek_q && speed_q > ceil_v) begin
					speed_q <= ceil_v;
					adj_q   <= 1'b1;
					ngv_q   <= s1_in_range;
					ng_q    <= s1_in_range ? s1_q[PW-1:0] : '0;
				end else if (!seek_q && goal_hit) begin
					minsp_q <= cfg.ceil_spd;
					adj_q   <= 1'b1;
					ngv_q   <= s1_in_range;
					ng_q    <= s1_in_range ? s1_q[PW-1:0] : '0;
				end
			end
			sip_pkg::S_MINSP: begin
				if (speed_q < min_v) begin
					adj_q <= 1'b1;
					if ((s0_q != s1_q) && seek_q) speed_q <= min_v;
				end
			end
			sip_pkg::S_DURDIV: begin
				if (div_stat.done) begin
					dur_q   <= quot[LW-1:0];
					speed_q <= min_v;
				end
			end
			sip_pkg::S_SILENCE: begin
				if (speed_q < VW'(cfg.silence_spd)) begin
					adj_q   <= 1'b1;
					speed_q <= '0;
				end
			end
			sip_pkg::S_ADJ2: begin
				s1_q <= (s0_q < s1_q) ? (s0_q + rnd_s) : (s0_q - rnd_s);
			end
			sip_pkg::S_BOUND: begin
				// clamp the end to the bounds, shortening or silencing the span
				an_q  <= an_c[PW-1:0];
				ad_q  <= ad_c;
				ns1_q <= ns1_c;
				if (s1_q != s0_q && !(seek_q && dur_q < cfg.stutter)) begin
					if (ns1_c == s1_q) begin
						if (dur_q == '0) begin
							silent_q <= 1'b1;
							s1_q     <= s0_q;
						end
					end else if (md_zero || dur_q == '0) begin
						silent_q <= 1'b1;
						s1_q     <= s0_q;
					end else if (an_c >= ad_c) begin
						s1_q <= ns1_c;
					end
				end
			end
			sip_pkg::S_MD2: lo_q <= prod_q;
			sip_pkg::S_MDDIV: begin
				if (div_stat.done) begin
					if (quot == '0) begin
						silent_q <= 1'b1;
						s1_q     <= s0_q;
					end else begin
						dur_q <= quot[LW-1:0];
						s1_q  <= ns1_q;
					end
				end
			end
			sip_pkg::S_SEEK2: begin
				// move the start back from the end, held inside the position range
				if (seek_s0 < 0) begin
					s0_q <= '0;
				end else if (seek_s0 > to_s(sip_pkg::POS_MAX)) begin
					s0_q <= to_s(sip_pkg::POS_MAX);
				end else begin
					s0_q <= seek_s0;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.status        = out_stat_q;
	assign out_ch.from_position = out_from_q;
	assign out_ch.to_position   = out_to_q;
	assign out_ch.span_length   = out_len_q;

	// a result is shown only while the sequencer waits for it to be taken
	a_out_in_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> state_q == sip_pkg::S_OUT)
		else $error("result valid outside the output state");

	// the divider is never restarted while it is still iterating
	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// empty and deferred results carry no interval
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status == sip_pkg::STAT_NONE ||
			out_ch.status == sip_pkg::STAT_DEFER)
		|-> out_ch.from_position == '0 && out_ch.to_position == '0 &&
			out_ch.span_length == '0)
		else $error("empty result carries an interval");

	// a refill always leaves the idle state
	a_refill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_ch.opcode == sip_pkg::OP_REFILL |=> state_q != sip_pkg::S_IDLE)
		else $error("refill accepted without work");

endmodule

### tb/tb_scrub_interval_planner.sv
// Self-checking testbench of the scrub interval planner: directed and random requests.
`timescale 1ns / 100ps

module tb_scrub_interval_planner;

	localparam logic [sip_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES = 600;
	localparam longint POS_TOP = 64'h00FF_FFFF_FFFF;
	localparam longint unsigned LEN_TOP = 64'hFF_FFFF;
	localparam longint unsigned SPD_TOP = 64'hFF_FFFF;
	localparam longint unsigned RATE_CAP = 64'h1_0000_0000;

	typedef struct {
		logic [sip_pkg::OP_W-1:0]  op;
		logic [sip_pkg::LEN_W-1:0] len;
		logic [sip_pkg::POS_W-1:0] pos;
		logic [sip_pkg::SPD_W-1:0] spd;
		logic                      seek;
	} req_t;

	typedef struct {
		sip_pkg::status_t          status;
		logic [sip_pkg::POS_W-1:0] from_pos;
		logic [sip_pkg::POS_W-1:0] to_pos;
		logic [sip_pkg::LEN_W-1:0] span;
	} span_t;

	// Tracks planner state and the spans it must emit
	class span_board;
		longint unsigned start_pos, lower, upper, floor_spd, ceil_spd, stutter, silence_spd;
		longint unsigned mode;
		longint iv_start, iv_end, goal;
		bit goal_ok, started, stopped;
		longint unsigned play_left, silence_left, deferred;
		span_t due[$];
		int errors;

		function new();
			start_pos = 0; lower = 0; upper = POS_TOP; floor_spd = 0; ceil_spd = 65536;
			stutter = 0; silence_spd = 655; mode = 0;
			iv_start = 0; iv_end = 0; goal = 0; goal_ok = 0; started = 0; stopped = 0;
			play_left = 0; silence_left = 0; deferred = 0; errors = 0;
		endfunction

		function void set_reg(sip_pkg::reg_idx_t idx, longint unsigned v);
			case (idx)
				sip_pkg::REG_START_POS: start_pos = v & POS_TOP;
				sip_pkg::REG_LOWER:     lower = v & POS_TOP;
				sip_pkg::REG_UPPER:     upper = v & POS_TOP;
				sip_pkg::REG_FLOOR:     floor_spd = v & SPD_TOP;
				sip_pkg::REG_CEIL:      ceil_spd = v & SPD_TOP;
				sip_pkg::REG_STUTTER:   stutter = v & SPD_TOP;
				sip_pkg::REG_SILENCE:   silence_spd = v & SPD_TOP;
				sip_pkg::REG_MODE:      mode = v & 3;
				default: ;
			endcase
		endfunction

		function longint unsigned round_q16(longint unsigned x);
			return (x + 64'd32768) >> sip_pkg::FRAC_W;
		endfunction

		function longint unsigned rate_of(longint unsigned travel, longint unsigned dur);
			longint unsigned q, r, v;
			if (dur == 0) return (travel != 0) ? RATE_CAP : 0;
			q = travel / dur;
			r = travel % dur;
			if ((q >> 16) != 0) return RATE_CAP;
			v = (q << sip_pkg::FRAC_W) + ((r << sip_pkg::FRAC_W) / dur);
			return (v > RATE_CAP) ? RATE_CAP : v;
		endfunction

		function longint clamp_pos(longint s);
			longint t;
			t = (s < longint'(upper)) ? s : longint'(upper);
			return (t > longint'(lower)) ? t : longint'(lower);
		endfunction

		function longint unsigned len_sum(longint unsigned a, longint unsigned b);
			return (a + b > LEN_TOP) ? LEN_TOP : a + b;
		endfunction

		// Plan one interval; zero means the seek stutter is deferred
		function bit plan_span(longint s0_in, longint unsigned dur_in, req_t r);
			longint s0, s1, n_goal, d, ns1, num, den;
			longint unsigned dur, spd, min_spd, travel, mag, delta, ndur, an, ad, sp2;
			bit seek, neg, n_ok, adj, silent;
			logic [127:0] prod;
			s0 = s0_in; dur = dur_in; seek = r.seek;
			n_goal = 0; n_ok = 0; adj = 0; silent = 0;
			if (mode[0]) begin
				neg = r.spd[sip_pkg::SPD_W-1];
				mag = neg ? (64'h100_0000 - longint'(r.spd)) : longint'(r.spd);
				delta = round_q16(dur * mag);
				s1 = neg ? s0 - longint'(delta) : s0 + longint'(delta);
			end else begin
				s1 = longint'(r.pos);
			end
			travel = (s1 > s0) ? s1 - s0 : s0 - s1;
			spd = rate_of(travel, dur);
			min_spd = (floor_spd < ceil_spd) ? floor_spd : ceil_spd;
			// catch up at the ceiling when too fast or the target stays put
			if (!seek && spd > ceil_spd) begin
				spd = ceil_spd; n_goal = s1; n_ok = 1; adj = 1;
			end else if (!seek && goal_ok && goal == s1) begin
				min_spd = ceil_spd; n_goal = s1; n_ok = 1; adj = 1;
			end
			if (n_ok && (n_goal < 0 || n_goal > POS_TOP)) begin
				n_ok = 0; n_goal = 0;
			end
			if (spd < min_spd) begin
				if (!(s0 != s1 && seek))
					dur = (spd * dur * 2 + min_spd) / (2 * min_spd);
				spd = min_spd; adj = 1;
			end
			if (spd < silence_spd) begin
				adj = 1; spd = 0;
			end
			if (adj && !seek) begin
				d = longint'(round_q16(spd * dur));
				s1 = (s0 < s1) ? s0 + d : s0 - d;
			end
			// clamp the end and shorten the duration to match
			if (s1 != s0) begin
				if (seek && dur < stutter) return 0;
				ndur = dur;
				ns1 = clamp_pos(s1);
				if (ns1 != s1) begin
					num = ns1 - s0;
					den = s1 - s0;
					if (num == 0 || ((num > 0) != (den > 0))) begin
						ndur = 0;
					end else begin
						an = (num > 0) ? num : -num;
						ad = (den > 0) ? den : -den;
						prod = {64'd0, dur} * {64'd0, an};
						ndur = (an >= ad) ? dur : longint'(prod / {64'd0, ad});
					end
				end
				if (ndur == 0) begin
					silent = 1; s1 = s0;
				end else if (ns1 != s1) begin
					dur = ndur; s1 = ns1;
				end
			end
			// move the start back from the end when seeking
			if (seek && !silent) begin
				sp2 = (ceil_spd < spd) ? ceil_spd : spd;
				d = longint'(round_q16(sp2 * dur));
				s0 = (s0 < s1) ? s1 - d : s1 + d;
				if (s0 < 0) s0 = 0;
				if (s0 > POS_TOP) s0 = POS_TOP;
			end
			iv_start = s0; iv_end = s1; goal = n_goal; goal_ok = n_ok;
			play_left = dur & LEN_TOP;
			silence_left = (dur < dur_in) ? dur_in - dur : 0;
			return 1;
		endfunction

		function void note(req_t r);
			span_t e;
			longint s0i, s0;
			longint unsigned dur;
			bit kb;
			e = '{sip_pkg::STAT_NONE, '0, '0, '0};
			kb = mode[1];
			s0i = 0;
			case (r.op)
				sip_pkg::OP_RESTART: begin
					started = 0; stopped = 0; deferred = 0; return;
				end
				sip_pkg::OP_STOP: begin
					stopped = 1; started = 0; return;
				end
				sip_pkg::OP_REFILL: ;
				default: return;
			endcase
			if (!started) begin
				s0i = clamp_pos(longint'(start_pos));
				if (!kb) begin
					iv_start = s0i; iv_end = s0i; goal_ok = 0; goal = 0;
					play_left = r.len; silence_left = 0;
				end
			end
			if (started || kb) begin
				dur = len_sum(r.len, deferred);
				s0 = started ? iv_end : s0i;
				if (plan_span(s0, dur, r)) begin
					deferred = 0;
				end else begin
					deferred = len_sum(deferred, dur);
					e.status = sip_pkg::STAT_DEFER;
					due.push_back(e);
					return;
				end
			end
			started = 1;
			if (stopped) begin
				e.status = sip_pkg::STAT_NONE;
			end else if (play_left > 0) begin
				e = '{sip_pkg::STAT_PLAY, iv_start[sip_pkg::POS_W-1:0],
					iv_end[sip_pkg::POS_W-1:0], play_left[sip_pkg::LEN_W-1:0]};
				play_left = 0;
			end else if (silence_left > 0) begin
				e = '{sip_pkg::STAT_SILENCE, iv_end[sip_pkg::POS_W-1:0],
					iv_end[sip_pkg::POS_W-1:0], silence_left[sip_pkg::LEN_W-1:0]};
				silence_left = 0;
			end
			due.push_back(e);
		endfunction

		function void check(span_t got);
			span_t e;
			if (due.size() == 0) begin
				$error("unexpected span beat: status %0d", got.status);
				errors++;
				return;
			end
			e = due.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, got.status); errors++;
			end
			if (got.from_pos !== e.from_pos) begin
				$error("from_position: expected %0d, actual %0d", e.from_pos, got.from_pos);
				errors++;
			end
			if (got.to_pos !== e.to_pos) begin
				$error("to_position: expected %0d, actual %0d", e.to_pos, got.to_pos); errors++;
			end
			if (got.span !== e.span) begin
				$error("span_length: expected %0d, actual %0d", e.span, got.span); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [sip_pkg::ADDR_W-1:0] paddr;
	logic [sip_pkg::DATA_W-1:0] pwdata, prdata;
	sip_in_if in_ch();
	sip_out_if out_ch();
	span_board board;
	bit calm, hold_req;

	scrub_interval_planner dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Note accepted requests and check spans
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			board.note('{in_ch.opcode, in_ch.request_length, in_ch.target_position,
				in_ch.target_speed, in_ch.seek_mode});
		if (out_ch.valid && out_ch.ready)
			board.check('{sip_pkg::status_t'(out_ch.status), out_ch.from_position,
				out_ch.to_position, out_ch.span_length});
	end

	// Abort when nothing moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(psel && penable))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Span receiver: random stalls, one long hold-off on request
	initial begin : receiver
		int gap;
		out_ch.ready <= 1'b0;
		forever begin
			gap = calm ? 0 : $urandom_range(0, 13);
			if (hold_req) begin
				hold_req = 0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic send_req(req_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= r.op;
		in_ch.request_length <= r.len;
		in_ch.target_position <= r.pos;
		in_ch.target_speed <= r.spd;
		in_ch.seek_mode <= r.seek;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic write_reg(sip_pkg::reg_idx_t idx, longint unsigned v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= sip_pkg::ADDR_W'(8 * int'(idx)); pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		board.set_reg(idx, v);
	endtask

	// Drop valid, drain every span, then let any silent item finish
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (board.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_all(longint unsigned sp, lo, hi, fl, ce, st, si, md);
		write_reg(sip_pkg::REG_START_POS, sp);
		write_reg(sip_pkg::REG_LOWER, lo);
		write_reg(sip_pkg::REG_UPPER, hi);
		write_reg(sip_pkg::REG_FLOOR, fl);
		write_reg(sip_pkg::REG_CEIL, ce);
		write_reg(sip_pkg::REG_STUTTER, st);
		write_reg(sip_pkg::REG_SILENCE, si);
		write_reg(sip_pkg::REG_MODE, md);
	endtask

	task automatic random_config();
		longint unsigned sp, lo, hi, fl, ce;
		int r;
		sp = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} & POS_TOP
			: $urandom_range(0, 2000000);
		r = $urandom_range(0, 99);
		if (r < 20) begin
			lo = 0; hi = POS_TOP;
		end else if (r < 25) begin
			lo = sp + 1000; hi = sp;
		end else begin
			lo = sp - $urandom_range(0, 100000);
			if (lo > sp) lo = 0;
			hi = sp + $urandom_range(0, 200000);
		end
		fl = $urandom_range(0, 40000);
		ce = fl + $urandom_range(0, 200000);
		write_all(sp, lo & POS_TOP, hi & POS_TOP, fl, ce,
			($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 3000),
			$urandom_range(0, 2000), $urandom_range(0, 3));
	endtask

	function automatic req_t random_req();
		req_t q;
		int r;
		longint near;
		r = $urandom_range(0, 99);
		q.op = (r < 6) ? sip_pkg::OP_RESTART : (r < 11) ? sip_pkg::OP_STOP
			: (r < 14) ? OP_UNUSED : sip_pkg::OP_REFILL;
		r = $urandom_range(0, 99);
		q.len = (r < 10) ? '0 : (r < 15) ? sip_pkg::LEN_MAX
			: (r < 25) ? sip_pkg::LEN_W'($urandom)
			: sip_pkg::LEN_W'($urandom_range(1, 3000));
		r = $urandom_range(0, 99);
		near = board.iv_end + $urandom_range(0, 8000) - 4000;
		if (r < 40) q.pos = sip_pkg::POS_W'(near);
		else if (r < 55) q.pos = sip_pkg::POS_W'(board.goal);
		else if (r < 70) q.pos = sip_pkg::POS_W'({$urandom, $urandom});
		else if (r < 78) q.pos = '0;
		else if (r < 86) q.pos = sip_pkg::POS_MAX;
		else q.pos = sip_pkg::POS_W'(board.lower + $urandom_range(0, 300000));
		r = $urandom_range(0, 99);
		if (r < 60) q.spd = sip_pkg::SPD_W'(int'($urandom_range(0, 200000)) - 100000);
		else if (r < 70) q.spd = sip_pkg::SPD_W'(int'($urandom_range(0, 2000)) - 1000);
		else if (r < 80) q.spd = sip_pkg::SPD_W'($urandom);
		else if (r < 85) q.spd = 24'h800000;
		else if (r < 90) q.spd = 24'h7FFFFF;
		else q.spd = '0;
		q.seek = ($urandom_range(0, 3) == 0);
		return q;
	endfunction

	initial begin : stimulus
		board = new();
		calm = 0; hold_req = 0;
		arst_n = 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		in_ch.valid <= 1'b0; in_ch.opcode <= sip_pkg::OP_RESTART;
		in_ch.request_length <= '0;
		in_ch.target_position <= '0; in_ch.target_speed <= '0; in_ch.seek_mode <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: first refill, catch-up, zero length, bounds, stop and restart
		send_req('{sip_pkg::OP_REFILL, 24'd100, 40'd500, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd100, 40'd500, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd100, 40'd500, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd0, 40'd900, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, sip_pkg::LEN_MAX, sip_pkg::POS_MAX, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd4000, 40'd0, '0, 1'b1});
		send_req('{sip_pkg::OP_STOP, 24'd10, 40'd0, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd10, 40'd20, '0, 1'b0});
		send_req('{sip_pkg::OP_RESTART, '0, '0, '0, 1'b0});
		send_req('{OP_UNUSED, sip_pkg::LEN_MAX, sip_pkg::POS_MAX, 24'hFFFFFF, 1'b1});
		send_req('{sip_pkg::OP_REFILL, 24'd50, 40'd70, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd5000, 40'd80, '0, 1'b0});
		settle();
		// Speed mode, inverted bounds, long stutter: deferral and slow speeds
		write_all(40'd100000, 40'd200000, 40'd150000, 24'd1000, 24'd90000, 24'd3000,
			24'd700, 2'd1);
		send_req('{sip_pkg::OP_RESTART, '0, '0, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd1000, '0, 24'd65536, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd1000, '0, 24'd20000, 1'b1});
		send_req('{sip_pkg::OP_REFILL, 24'd1000, '0, 24'h7FFFFF, 1'b1});
		send_req('{sip_pkg::OP_REFILL, 24'd2000, '0, 24'h800000, 1'b1});
		settle();
		// Keyboard speed mode over the full range
		write_all(40'd5000, 40'd0, POS_TOP, 24'd0, 24'd131072, 24'd100, 24'd655, 2'd3);
		send_req('{sip_pkg::OP_RESTART, '0, '0, '0, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd300, '0, 24'h800000, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd300, '0, 24'd100, 1'b0});
		send_req('{sip_pkg::OP_REFILL, 24'd50, '0, 24'hFF0000, 1'b1});
		send_req('{sip_pkg::OP_REFILL, 24'd300, '0, 24'h7FFFFF, 1'b0});
		settle();

		// Random phases, the first three at fixed settings: reset values, all maximum, all zero
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: write_all(0, 0, POS_TOP, 0, 65536, 0, 655, 0);
				1: write_all(POS_TOP, POS_TOP, POS_TOP, SPD_TOP, SPD_TOP, SPD_TOP, SPD_TOP, 3);
				2: write_all(0, 0, 0, 0, 0, 0, 0, 0);
				default: random_config();
			endcase
			calm = (p == 4);
			if (p == 3) hold_req = 1;
			send_req('{sip_pkg::OP_RESTART, '0, '0, '0, 1'b0});
			repeat (60) send_req(random_req());
			settle();
		end

		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
